@@ src/csem_pkg.sv @@
// Package for the counting semaphore table: field widths, op and status codes,
// the command record passed from front to back, and width helpers.
// No dependencies.
package csem_pkg;

   localparam int OP_W       = 3;
   localparam int SEM_ID_W   = 4;
   localparam int PID_W      = 16;
   localparam int COUNT_W    = 16;
   localparam int STATUS_W   = 2;

   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 16;
   localparam int RSP_TUSER_W = 3;

   localparam int NUM_SEMS_DEF    = 16;
   localparam int QUEUE_DEPTH_DEF = 8;
   localparam int CMDQ_DEPTH      = 2;

   // op field codes on the request channel
   localparam logic [OP_W-1:0] OP_INIT  = 3'd0;
   localparam logic [OP_W-1:0] OP_POST  = 3'd1;
   localparam logic [OP_W-1:0] OP_WAIT  = 3'd2;
   localparam logic [OP_W-1:0] OP_CLOSE = 3'd3;
   localparam logic [OP_W-1:0] OP_OPEN  = 3'd4;

   // status field codes on the response channel
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BLOCKED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

   typedef enum logic [2:0] {
      KIND_INIT,
      KIND_POST,
      KIND_WAIT,
      KIND_CLOSE,
      KIND_OPEN,
      KIND_BAD
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [SEM_ID_W-1:0]   sem_id;
      logic [PID_W-1:0]      pid;
      logic [COUNT_W-1:0]    init_value;
   } cmd_type;

   function automatic int idx_width(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

@@ src/counting_semaphore_table.sv @@
// Counting semaphore table. A request passes the command queue, then the back end's
// issue and execute states; a post that releases a waiter adds a wake state (extra
// read of the waiter memory). Commands run one at a time, set by the read-modify-write
// of the entry table through its single registered read port.
// Reset (synchronous): clears all valid flags, the command queue and control state;
// the entry table and waiter memory are not cleared, init writes an entry before any use.
module counting_semaphore_table import csem_pkg::*; #(
   parameter int NUM_SEMS    = NUM_SEMS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // req_tdata: sem_id[3:0], pid[19:4], init_value[35:20], zero[39:36]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_tuser: op[2:0]
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // rsp_tdata: woken_pid[15:0]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // rsp_tuser: status[1:0], woken_valid[2]
   output logic [RSP_TUSER_W-1:0] rsp_tuser
);

   // front to queue
   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;

   // queue to back
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_cmd;

   // Decode op and sem_id into a command kind; out-of-range ids and unknown
   // ops collapse into one kind that always answers "missing".
   csem_front #(
      .NUM_SEMS (NUM_SEMS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   // Hold decoded commands so the request side keeps accepting while the back
   // end works through a read-modify-write or waits on a stalled response.
   csem_cmdq u_cmdq (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // Execute one command at a time: read the entry record, update count and
   // queue pointers, push or pop the waiter memory, and register the response.
   csem_back #(
      .NUM_SEMS    (NUM_SEMS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ src/csem_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module csem_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/csem_front.sv @@
// Front end: unpack the request bus and classify each request into a command.
// Depends on csem_pkg.
module csem_front import csem_pkg::*; #(
   parameter int NUM_SEMS = NUM_SEMS_DEF
) (
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   push_valid,
   input  logic                   push_ready,
   output cmd_type                push_cmd
);

   logic [OP_W-1:0]     op;
   logic [SEM_ID_W-1:0] sem_id;
   logic                in_range;
   kind_type            kind;

   assign op     = req_tuser[2:0];
   assign sem_id = req_tdata[3:0];

   // ids beyond the table are treated like an unknown op
   assign in_range = ({8'd0, sem_id} < 12'(NUM_SEMS));

   always_comb begin
      kind = KIND_BAD;
      if (in_range) begin
         unique case (op)
            OP_INIT:  kind = KIND_INIT;
            OP_POST:  kind = KIND_POST;
            OP_WAIT:  kind = KIND_WAIT;
            OP_CLOSE: kind = KIND_CLOSE;
            OP_OPEN:  kind = KIND_OPEN;
            default:  kind = KIND_BAD;
         endcase
      end
   end

   assign push_cmd.kind       = kind;
   assign push_cmd.sem_id     = sem_id;
   assign push_cmd.pid        = req_tdata[19:4];
   assign push_cmd.init_value = req_tdata[35:20];

   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

endmodule

@@ src/csem_cmdq.sv @@
// Short command queue between front and back so each side stalls on its own.
// Depends on csem_pkg.
module csem_cmdq import csem_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   localparam int PTR_W = idx_width(CMDQ_DEPTH);
   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type          slot_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign push_ready = (fill_ff != CNT_W'(CMDQ_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ src/csem_back.sv @@
// Back end: read-modify-write of the entry table and waiter memory, result register.
// Depends on csem_pkg and csem_ram.
module csem_back import csem_pkg::*; #(
   parameter int NUM_SEMS    = NUM_SEMS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  cmd_type                pop_cmd,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [RSP_TUSER_W-1:0] rsp_tuser
);

   localparam int SEM_W  = idx_width(NUM_SEMS);
   localparam int PTR_W  = idx_width(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int REC_W  = COUNT_W + 2 * PTR_W + FILL_W;
   localparam int PID_DEPTH = NUM_SEMS * QUEUE_DEPTH;
   localparam int PID_AW = idx_width(PID_DEPTH);

   localparam logic [1:0] S_ISSUE = 2'd0;
   localparam logic [1:0] S_EXEC  = 2'd1;
   localparam logic [1:0] S_WAKE  = 2'd2;

   logic [1:0]          state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [NUM_SEMS-1:0] valid_ff, valid_in;

   logic                out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] out_status_ff;
   logic                out_wv_ff;
   logic [PID_W-1:0]    out_wpid_ff;
   logic                out_load, out_free;
   logic [STATUS_W-1:0] res_status;
   logic                res_wv;
   logic [PID_W-1:0]    res_wpid;

   logic [11:0]         pop_ext, cur_ext;
   logic [SEM_W-1:0]    pop_idx, cur_idx;
   logic                cur_valid;

   logic [SEM_W-1:0]    ent_rd_addr;
   logic [REC_W-1:0]    ent_rdata, ent_wdata;
   logic                ent_we;

   logic [COUNT_W-1:0]  count;
   logic [PTR_W-1:0]    head, tail, head_nxt, tail_nxt;
   logic [FILL_W-1:0]   fill;

   logic [PID_AW-1:0]   pid_base, pid_rd_addr, pid_wr_addr;
   logic [PID_W-1:0]    pid_rdata;
   logic                pid_we;

   assign pop_ext = {8'd0, pop_cmd.sem_id};
   assign cur_ext = {8'd0, cmd_ff.sem_id};
   assign pop_idx = pop_ext[SEM_W-1:0];
   assign cur_idx = cur_ext[SEM_W-1:0];
   assign cur_valid = valid_ff[cur_idx];

   assign pop_ready   = (state_ff == S_ISSUE);
   assign ent_rd_addr = (state_ff == S_ISSUE) ? pop_idx : cur_idx;

   // entry record: {count, head, tail, fill}
   assign fill  = ent_rdata[FILL_W-1:0];
   assign tail  = ent_rdata[FILL_W +: PTR_W];
   assign head  = ent_rdata[FILL_W + PTR_W +: PTR_W];
   assign count = ent_rdata[REC_W-1 -: COUNT_W];

   assign head_nxt = (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
   assign tail_nxt = (tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;

   assign pid_base    = PID_AW'(cur_idx) * PID_AW'(QUEUE_DEPTH);
   assign pid_rd_addr = pid_base + PID_AW'(head);
   assign pid_wr_addr = pid_base + PID_AW'(tail);

   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      valid_in   = valid_ff;
      ent_we     = 1'b0;
      ent_wdata  = ent_rdata;
      pid_we     = 1'b0;
      out_load   = 1'b0;
      res_status = ST_MISSING;
      res_wv     = 1'b0;
      res_wpid   = '0;
      unique case (state_ff)
         S_ISSUE: begin
            if (pop_valid) begin
               cmd_in   = pop_cmd;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = S_ISSUE;
               out_load = 1'b1;
               unique case (cmd_ff.kind)
                  KIND_INIT: begin
                     if (!cur_valid) begin
                        valid_in[cur_idx] = 1'b1;
                        ent_we     = 1'b1;
                        ent_wdata  = {cmd_ff.init_value, {PTR_W{1'b0}}, {PTR_W{1'b0}},
                                      {FILL_W{1'b0}}};
                        res_status = ST_OK;
                     end
                  end
                  KIND_POST: begin
                     if (cur_valid) begin
                        res_status = ST_OK;
                        if (fill != '0) begin
                           // pop the oldest waiter; its pid arrives next cycle
                           ent_we    = 1'b1;
                           ent_wdata = {count, head_nxt, tail, fill - 1'b1};
                           out_load  = 1'b0;
                           state_in  = S_WAKE;
                        end else if (count != '1) begin
                           ent_we    = 1'b1;
                           ent_wdata = {count + 1'b1, head, tail, fill};
                        end
                     end
                  end
                  KIND_WAIT: begin
                     if (cur_valid) begin
                        if (count != '0) begin
                           ent_we     = 1'b1;
                           ent_wdata  = {count - 1'b1, head, tail, fill};
                           res_status = ST_OK;
                        end else if (fill == FILL_W'(QUEUE_DEPTH)) begin
                           res_status = ST_FULL;
                        end else begin
                           pid_we     = 1'b1;
                           ent_we     = 1'b1;
                           ent_wdata  = {count, head, tail_nxt, fill + 1'b1};
                           res_status = ST_BLOCKED;
                        end
                     end
                  end
                  KIND_CLOSE: begin
                     if (cur_valid) begin
                        valid_in[cur_idx] = 1'b0;
                        res_status = ST_OK;
                     end
                  end
                  KIND_OPEN: begin
                     if (cur_valid) begin
                        res_status = ST_OK;
                     end
                  end
                  default: begin
                     res_status = ST_MISSING;
                  end
               endcase
            end
         end
         S_WAKE: begin
            out_load   = 1'b1;
            res_status = ST_OK;
            res_wv     = 1'b1;
            res_wpid   = pid_rdata;
            state_in   = S_ISSUE;
         end
         default: begin
            state_in = S_ISSUE;
         end
      endcase
   end

   assign out_valid_in = out_load || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_ISSUE;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (out_load) begin
         out_status_ff <= res_status;
         out_wv_ff     <= res_wv;
         out_wpid_ff   <= res_wpid;
      end
   end

   csem_ram #(
      .WIDTH  (REC_W),
      .DEPTH  (NUM_SEMS),
      .ADDR_W (SEM_W)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (cur_idx),
      .wr_data (ent_wdata),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rdata)
   );

   csem_ram #(
      .WIDTH  (PID_W),
      .DEPTH  (PID_DEPTH),
      .ADDR_W (PID_AW)
   ) u_pid_ram (
      .clock   (clock),
      .wr_en   (pid_we),
      .wr_addr (pid_wr_addr),
      .wr_data (cmd_ff.pid),
      .rd_addr (pid_rd_addr),
      .rd_data (pid_rdata)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_wpid_ff;
   assign rsp_tuser  = {out_wv_ff, out_status_ff};

endmodule

@@ bench/tb.sv @@
// Self-checking bench for counting_semaphore_table: directed table, then random requests.
// Predicts every response with a local semaphore/wait-queue model; depends on csem_pkg and the design.
module tb import csem_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSEM        = NUM_SEMS_DEF;
   localparam int QDEPTH      = QUEUE_DEPTH_DEF;
   localparam int ITEMS_PER_PHASE = 450;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [SEM_ID_W-1:0] sem_id;
      logic [PID_W-1:0]    pid;
      logic [COUNT_W-1:0]  init_value;
   } sem_request_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                woken_valid;
      logic [PID_W-1:0]    woken_pid;
   } sem_reply_type;

   // one row of the directed table; pinned rows carry a hand-written reply
   typedef struct {
      sem_request_type req;
      bit              pinned;
      sem_reply_type   reply;
   } directed_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   // travel with req_tdata so the monitor knows which reply to hold for a request
   bit            req_pinned;
   sem_reply_type req_pinned_reply;

   int sender_idle_pct;
   int receiver_stall_pct;
   int fail_count;
   int cycle_count;

   // shadow of the semaphore table
   bit                 shadow_live  [NSEM];
   logic [COUNT_W-1:0] shadow_count [NSEM];
   logic [PID_W-1:0]   shadow_waiter[NSEM][QDEPTH];
   int                 shadow_head  [NSEM];
   int                 shadow_tail  [NSEM];
   int                 shadow_fill  [NSEM];

   sem_reply_type    replies_due[$];
   directed_row_type directed_rows[$];

   counting_semaphore_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Apply one request to the shadow table and return the reply it should produce.
   function automatic sem_reply_type semaphore_outcome(input sem_request_type r);
      sem_reply_type rep;
      int            s;
      bit            exists;
      rep    = '{status: ST_MISSING, woken_valid: 1'b0, woken_pid: '0};
      s      = int'(r.sem_id);
      exists = shadow_live[s];
      case (r.op)
         OP_INIT: begin
            if (!exists) begin
               shadow_live[s]  = 1'b1;
               shadow_count[s] = r.init_value;
               shadow_head[s]  = 0;
               shadow_tail[s]  = 0;
               shadow_fill[s]  = 0;
               rep.status      = ST_OK;
            end
         end
         OP_POST: begin
            if (exists) begin
               // hand the unit to the oldest waiter, else bump the count up to its ceiling
               if (shadow_fill[s] > 0) begin
                  rep.woken_valid = 1'b1;
                  rep.woken_pid   = shadow_waiter[s][shadow_head[s]];
                  shadow_head[s]  = (shadow_head[s] == QDEPTH - 1) ? 0 : shadow_head[s] + 1;
                  shadow_fill[s]--;
               end else if (shadow_count[s] != '1) begin
                  shadow_count[s] = shadow_count[s] + 1'b1;
               end
               rep.status = ST_OK;
            end
         end
         OP_WAIT: begin
            if (exists) begin
               if (shadow_count[s] != '0) begin
                  shadow_count[s] = shadow_count[s] - 1'b1;
                  rep.status      = ST_OK;
               end else if (shadow_fill[s] >= QDEPTH) begin
                  rep.status = ST_FULL;
               end else begin
                  shadow_waiter[s][shadow_tail[s]] = r.pid;
                  shadow_tail[s] = (shadow_tail[s] == QDEPTH - 1) ? 0 : shadow_tail[s] + 1;
                  shadow_fill[s]++;
                  rep.status = ST_BLOCKED;
               end
            end
         end
         OP_CLOSE: begin
            if (exists) begin
               // drop the waiters along with the entry
               shadow_live[s] = 1'b0;
               shadow_head[s] = 0;
               shadow_tail[s] = 0;
               shadow_fill[s] = 0;
               rep.status     = ST_OK;
            end
         end
         OP_OPEN: begin
            rep.status = exists ? ST_OK : ST_MISSING;
         end
         default: begin
            rep.status = ST_MISSING;
         end
      endcase
      return rep;
   endfunction

   task automatic add_row(input logic [OP_W-1:0] op, input int sem, input int pid,
                          input int ival, input bit pinned, input logic [STATUS_W-1:0] st,
                          input bit wv, input int wpid);
      directed_row_type row;
      row.req    = '{op: op, sem_id: sem[SEM_ID_W-1:0], pid: pid[PID_W-1:0],
                     init_value: ival[COUNT_W-1:0]};
      row.pinned = pinned;
      row.reply  = '{status: st, woken_valid: wv, woken_pid: wpid[PID_W-1:0]};
      directed_rows.push_back(row);
   endtask

   // Present one request from the falling edge on and hold it until accepted.
   task automatic issue_request(input sem_request_type r, input bit pinned,
                                input sem_reply_type want);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid       <= 1'b1;
      req_tdata        <= {4'd0, r.init_value, r.pid, r.sem_id};
      req_tuser        <= r.op;
      req_pinned       <= pinned;
      req_pinned_reply <= want;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Receiver back-pressure; one assignment per falling edge.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Predict on request accept, check on response accept; both in one block to keep order fixed.
   always @(posedge clock) begin : monitor
      sem_request_type seen;
      sem_reply_type   predicted;
      sem_reply_type   want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            seen.op         = req_tuser[2:0];
            seen.sem_id     = req_tdata[3:0];
            seen.pid        = req_tdata[19:4];
            seen.init_value = req_tdata[35:20];
            predicted = semaphore_outcome(seen);
            replies_due.push_back(req_pinned ? req_pinned_reply : predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (replies_due.size() == 0) begin
               $error("response with no request outstanding: rsp_tdata=%h rsp_tuser=%h",
                      rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               want = replies_due.pop_front();
               if (rsp_tuser[1:0] !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_tuser[1:0]);
                  fail_count++;
               end
               if (rsp_tuser[2] !== want.woken_valid) begin
                  $error("woken_valid: expected %0d, actual %0d", want.woken_valid,
                         rsp_tuser[2]);
                  fail_count++;
               end
               if (rsp_tdata[15:0] !== want.woken_pid) begin
                  $error("woken_pid: expected %h, actual %h", want.woken_pid, rsp_tdata[15:0]);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin : main
      bit              timed_out;
      sem_request_type r;
      sem_reply_type   no_reply;
      int              pick;

      timed_out          = 1'b0;
      fail_count         = 0;
      cycle_count        = 0;
      reset              = 1'b1;
      req_tvalid         = 1'b0;
      req_tdata          = '0;
      req_tuser          = '0;
      req_pinned         = 1'b0;
      req_pinned_reply   = '0;
      rsp_tready         = 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      no_reply           = '0;
      for (int s = 0; s < NSEM; s++) begin
         shadow_live[s]  = 1'b0;
         shadow_count[s] = '0;
         shadow_head[s]  = 0;
         shadow_tail[s]  = 0;
         shadow_fill[s]  = 0;
      end

      // Directed table: empty-table misses, init twice, fill a queue to overflow,
      // release the oldest waiter, close, count ceiling, unknown ops.
      add_row(OP_OPEN,  0,  16'h0000, 16'h0000, 1, ST_MISSING, 0, 0);
      add_row(OP_POST,  1,  16'h0000, 16'h0000, 1, ST_MISSING, 0, 0);
      add_row(OP_WAIT,  15, 16'hFFFF, 16'hFFFF, 1, ST_MISSING, 0, 0);
      add_row(OP_CLOSE, 3,  16'h0000, 16'h0000, 1, ST_MISSING, 0, 0);
      add_row(OP_INIT,  0,  16'h0000, 16'h0000, 1, ST_OK,      0, 0);
      add_row(OP_INIT,  0,  16'h0000, 16'h0007, 1, ST_MISSING, 0, 0);
      add_row(OP_WAIT,  0,  16'hFFFF, 16'h0000, 1, ST_BLOCKED, 0, 0);
      add_row(OP_WAIT,  0,  16'h0000, 16'h0000, 1, ST_BLOCKED, 0, 0);
      add_row(OP_WAIT,  0,  16'h5555, 16'h0000, 1, ST_BLOCKED, 0, 0);
      add_row(OP_WAIT,  0,  16'hAAAA, 16'h0000, 1, ST_BLOCKED, 0, 0);
      add_row(OP_WAIT,  0,  16'h1234, 16'h0000, 1, ST_BLOCKED, 0, 0);
      add_row(OP_WAIT,  0,  16'h8000, 16'h0000, 1, ST_BLOCKED, 0, 0);
      add_row(OP_WAIT,  0,  16'h7FFF, 16'h0000, 1, ST_BLOCKED, 0, 0);
      add_row(OP_WAIT,  0,  16'h0001, 16'h0000, 1, ST_BLOCKED, 0, 0);
      add_row(OP_WAIT,  0,  16'h4321, 16'h0000, 1, ST_FULL,    0, 0);
      add_row(OP_POST,  0,  16'h0000, 16'h0000, 1, ST_OK,      1, 16'hFFFF);
      add_row(OP_OPEN,  0,  16'h0000, 16'h0000, 1, ST_OK,      0, 0);
      add_row(OP_CLOSE, 0,  16'h0000, 16'h0000, 1, ST_OK,      0, 0);
      add_row(OP_POST,  0,  16'h0000, 16'h0000, 1, ST_MISSING, 0, 0);
      add_row(OP_INIT,  15, 16'h0000, 16'hFFFF, 1, ST_OK,      0, 0);
      add_row(OP_POST,  15, 16'h0000, 16'h0000, 1, ST_OK,      0, 0);
      add_row(OP_WAIT,  15, 16'h2222, 16'h0000, 0, ST_OK,      0, 0);
      add_row(3'd5,     15, 16'h0000, 16'h0000, 1, ST_MISSING, 0, 0);
      add_row(3'd7,     0,  16'hFFFF, 16'hFFFF, 1, ST_MISSING, 0, 0);

      fork
         begin
            repeat (7) @(posedge clock);
            @(negedge clock);
            reset <= 1'b0;
            @(negedge clock);

            // phases: no idling, sender gaps, receiver stalls, both
            for (int phase = 0; phase < 4; phase++) begin
               sender_idle_pct    = (phase == 1) ? 53 : (phase == 3) ? 36 : 0;
               receiver_stall_pct = (phase == 2) ? 53 : (phase == 3) ? 36 : 0;
               if (phase == 0) begin
                  foreach (directed_rows[i])
                     issue_request(directed_rows[i].req, directed_rows[i].pinned,
                                   directed_rows[i].reply);
               end
               repeat (ITEMS_PER_PHASE) begin
                  // hammer a few hot entries so queues fill and counts run dry
                  r.sem_id = ($urandom_range(0, 99) < 75) ? SEM_ID_W'($urandom_range(0, 3))
                                                          : SEM_ID_W'($urandom_range(0, NSEM - 1));
                  pick = $urandom_range(0, 99);
                  if (pick < 10)      r.op = OP_INIT;
                  else if (pick < 36) r.op = OP_POST;
                  else if (pick < 72) r.op = OP_WAIT;
                  else if (pick < 79) r.op = OP_CLOSE;
                  else if (pick < 95) r.op = OP_OPEN;
                  else                r.op = OP_W'($urandom_range(5, 7));
                  r.pid = PID_W'($urandom_range(0, 65535));
                  case ($urandom_range(0, 7))
                     0:       r.init_value = '0;
                     1:       r.init_value = '1;
                     2:       r.init_value = 16'hFFFE;
                     3, 4, 5: r.init_value = COUNT_W'($urandom_range(0, 3));
                     default: r.init_value = COUNT_W'($urandom_range(0, 65535));
                  endcase
                  issue_request(r, 1'b0, no_reply);
               end
            end
            req_tvalid <= 1'b0;

            // drain, then give the pipeline a few idle cycles
            while (replies_due.size() != 0) @(posedge clock);
            repeat (DRAIN_CYCLES) @(posedge clock);
         end
         begin
            wait (cycle_count >= CYCLE_LIMIT);
            timed_out = 1'b1;
         end
      join_any
      disable fork;

      if (!timed_out && fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
